FILE: hw/rtl/line_editor_echo_defines.svh
// Assertion macros used by the line editor top level.
`ifndef LINE_EDITOR_ECHO_DEFINES_SVH
`define LINE_EDITOR_ECHO_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LEE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LEE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/lee_pkg.sv
// Types and constants of the line editor.
package lee_pkg;

    // Cursor width covers every supported line length.
    localparam int CUR_W = 6;

    // Byte codes.
    localparam logic [7:0] CODE_CTRL_W = 8'd23;
    localparam logic [7:0] CODE_CTRL_D = 8'd4;
    localparam logic [7:0] CODE_BEL    = 8'd7;
    localparam logic [7:0] CODE_CR     = 8'd13;
    localparam logic [7:0] CODE_NL     = 8'd10;
    localparam logic [7:0] CODE_SPACE  = 8'd32;
    localparam logic [7:0] CODE_CTL_HI = 8'd31;
    localparam logic [7:0] CODE_DEL    = 8'd127;

    // Reset values of the configuration registers.
    localparam logic [7:0] ERASE_RST = 8'd127;
    localparam logic [7:0] KILL_RST  = 8'd21;

    // Register indexes on the configuration port.
    localparam logic REG_ERASE = 1'b0;
    localparam logic REG_KILL  = 1'b1;

    // Clear-line sequence ESC [ 1 K followed by CR.
    localparam logic [7:0] CLEAR_SEQ [4] = '{8'd27, 8'd91, 8'd49, 8'd75};
    localparam logic [2:0] CLEAR_CR_IDX = 3'd4;

    // Command decoded from one typed byte.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_ERASE,
        OP_KILL,
        OP_WORD,
        OP_END,
        OP_BEL,
        OP_ECHO,
        OP_FULL
    } t_op;

    typedef struct packed {
        t_op  op;
        logic newline;
    } t_cmd;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_CLEAR,
        ST_RETYPE
    } t_state;

endpackage

FILE: hw/rtl/lee_decode.sv
// Classifies a typed byte into an editor command by priority.
module lee_decode (
    input  logic          [7:0] i_byte,
    input  logic          [7:0] i_erase_char,
    input  logic          [7:0] i_kill_char,
    input  logic                i_ended,
    input  logic                i_cursor_zero,
    input  logic                i_line_full,
    output lee_pkg::t_cmd       o_cmd
);
    import lee_pkg::*;

    // Checks run in fixed priority: ended session, erase, kill, word erase, end, control, store.
    always_comb begin
        o_cmd.newline = (i_byte == CODE_NL);
        if (i_ended) begin
            o_cmd.op = OP_NONE;
        end else if (i_byte == i_erase_char) begin
            o_cmd.op = i_cursor_zero ? OP_NONE : OP_ERASE;
        end else if (i_byte == i_kill_char) begin
            o_cmd.op = OP_KILL;
        end else if (i_byte == CODE_CTRL_W) begin
            o_cmd.op = OP_WORD;
        end else if (i_byte == CODE_CTRL_D) begin
            o_cmd.op = i_cursor_zero ? OP_END : OP_NONE;
        end else if ((i_byte <= CODE_CTL_HI || i_byte >= CODE_DEL) && i_byte != CODE_NL) begin
            o_cmd.op = OP_BEL;
        end else if (!i_line_full) begin
            o_cmd.op = OP_ECHO;
        end else begin
            o_cmd.op = OP_FULL;
        end
    end

endmodule

FILE: hw/rtl/line_editor_echo.sv
// Top level of the line editor: line store, cursor, sequencer and result register.
//
// Input channel: one typed byte per beat (i_in_valid / o_in_ready / i_in_byte).
// Output channel: one echo result per beat (o_out_valid / i_out_ready) with
// o_out_byte, o_byte_valid, o_session_end and o_last; o_last marks the final
// result caused by an input byte. An input that causes no result gives no beat.
// Configuration: APB-style port, erase_char at address 0, kill_char at 4.
// Steps per item: a byte that gives one result (echo, bell, full line,
// session end) or none goes straight to the result register. Kill sends the
// clear-line sequence and CR; erase sends them and then retypes the stored
// line up to the new cursor; word erase first walks back through the stored
// bytes to the word boundary, then clears and retypes. The sequencer moves one
// byte per cycle through the single read port of the line store, which sets
// the pace, and waits while the receiver stalls. A single result is registered
// and appears in the cycle after the input beat; erase and kill give their
// first result from the clear state after it, and word erase after the walk.
// Reset clears the cursor, the session-ended flag and both registers to their
// defaults; the line store is not cleared. When the receiver stalls, the
// result register holds its beat and the sequencer waits; a new input is
// taken only when the sequencer is idle and the result register can load.
module line_editor_echo #(
    parameter int LINE_LENGTH = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    // Output channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_session_end,
    output logic        o_last,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lee_pkg::*;
    `include "line_editor_echo_defines.svh"

    localparam int AW = (LINE_LENGTH > 1) ? $clog2(LINE_LENGTH) : 1;
    localparam logic [CUR_W-1:0] LINE_LEN_C = CUR_W'(LINE_LENGTH);

    // Registers.
    t_state           r_state, n_state;
    logic [CUR_W-1:0] r_cursor, n_cursor;
    logic [CUR_W-1:0] r_idx, n_idx;
    logic [2:0]       r_cnt, n_cnt;
    logic             r_ended, n_ended;
    logic             r_seen, n_seen;
    logic             r_retype, n_retype;
    logic [7:0]       r_erase, r_kill;
    logic [7:0]       r_line [LINE_LENGTH];
    logic [7:0]       r_rd_data;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_byte, n_out_byte;
    logic             r_out_bvalid, n_out_bvalid;
    logic             r_out_end, n_out_end;
    logic             r_out_last, n_out_last;

    // Combinational signals.
    t_cmd             cmd;
    logic             slot_free;
    logic             in_fire;
    logic             emit;
    logic             mem_we;
    logic [CUR_W-1:0] rd_ptr;
    logic             cfg_we;

    // Configuration register access.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;
    assign prdata = {24'd0, (paddr[2] == REG_KILL) ? r_kill : r_erase};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_erase <= ERASE_RST;
            r_kill  <= KILL_RST;
        end else if (cfg_we) begin
            if (paddr[2] == REG_ERASE) begin
                r_erase <= pwdata[7:0];
            end else begin
                r_kill <= pwdata[7:0];
            end
        end
    end

    // Handshakes.
    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && slot_free;
    assign in_fire    = i_in_valid && o_in_ready;

    // Byte classification.
    lee_decode u_decode (
        .i_byte        (i_in_byte),
        .i_erase_char  (r_erase),
        .i_kill_char   (r_kill),
        .i_ended       (r_ended),
        .i_cursor_zero (r_cursor == '0),
        .i_line_full   (r_cursor >= LINE_LEN_C),
        .o_cmd         (cmd)
    );

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (cmd.op)
                        OP_ERASE, OP_KILL: n_state = ST_CLEAR;
                        OP_WORD:           n_state = ST_WALK;
                        default:           n_state = ST_IDLE;
                    endcase
                end
            end
            ST_WALK: begin
                if (r_idx == '0) begin
                    n_state = ST_CLEAR;
                end else if (r_rd_data != CODE_SPACE && r_seen) begin
                    n_state = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                if (slot_free && r_cnt == CLEAR_CR_IDX) begin
                    n_state = (r_retype && r_cursor != '0) ? ST_RETYPE : ST_IDLE;
                end
            end
            ST_RETYPE: begin
                if (slot_free && r_idx == r_cursor - CUR_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and result generation of the sequencer.
    always_comb begin
        n_cursor     = r_cursor;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_ended      = r_ended;
        n_seen       = r_seen;
        n_retype     = r_retype;
        emit         = 1'b0;
        mem_we       = 1'b0;
        n_out_byte   = r_out_byte;
        n_out_bvalid = r_out_bvalid;
        n_out_end    = r_out_end;
        n_out_last   = r_out_last;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_cnt    = '0;
                    n_seen   = 1'b0;
                    n_idx    = '0;
                    n_retype = 1'b1;
                    case (cmd.op)
                        OP_ERASE: begin
                            n_cursor = r_cursor - CUR_W'(1);
                        end
                        OP_KILL: begin
                            n_cursor = '0;
                            n_retype = 1'b0;
                        end
                        OP_WORD: begin
                            n_idx = r_cursor;
                        end
                        OP_END: begin
                            n_ended      = 1'b1;
                            emit         = 1'b1;
                            n_out_byte   = '0;
                            n_out_bvalid = 1'b0;
                            n_out_end    = 1'b1;
                            n_out_last   = 1'b1;
                        end
                        OP_BEL: begin
                            emit         = 1'b1;
                            n_out_byte   = CODE_BEL;
                            n_out_bvalid = 1'b1;
                            n_out_end    = 1'b0;
                            n_out_last   = 1'b1;
                        end
                        OP_ECHO: begin
                            emit         = 1'b1;
                            mem_we       = 1'b1;
                            n_out_byte   = i_in_byte;
                            n_out_bvalid = 1'b1;
                            n_out_end    = 1'b0;
                            n_out_last   = 1'b1;
                            n_cursor     = cmd.newline ? '0 : r_cursor + CUR_W'(1);
                        end
                        OP_FULL: begin
                            emit         = 1'b1;
                            n_out_byte   = CODE_NL;
                            n_out_bvalid = 1'b1;
                            n_out_end    = 1'b0;
                            n_out_last   = 1'b1;
                            n_cursor     = '0;
                        end
                        default: begin
                            n_idx = r_idx;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                // Walk back over the word and the spaces before it.
                if (r_idx == '0) begin
                    n_cursor = '0;
                end else if (r_rd_data == CODE_SPACE) begin
                    n_seen = 1'b1;
                    n_idx  = r_idx - CUR_W'(1);
                end else if (r_seen) begin
                    n_cursor = r_idx;
                    n_idx    = '0;
                end else begin
                    n_idx = r_idx - CUR_W'(1);
                end
                if (n_state == ST_CLEAR) begin
                    n_idx = '0;
                end
            end
            ST_CLEAR: begin
                // Clear-line sequence, then CR.
                if (slot_free) begin
                    emit         = 1'b1;
                    n_out_bvalid = 1'b1;
                    n_out_end    = 1'b0;
                    if (r_cnt == CLEAR_CR_IDX) begin
                        n_out_byte = CODE_CR;
                        n_out_last = !(r_retype && r_cursor != '0);
                    end else begin
                        n_out_byte = CLEAR_SEQ[r_cnt[1:0]];
                        n_out_last = 1'b0;
                        n_cnt      = r_cnt + 3'd1;
                    end
                end
            end
            ST_RETYPE: begin
                // Retype the stored line, one byte per beat.
                if (slot_free) begin
                    emit         = 1'b1;
                    n_out_byte   = r_rd_data;
                    n_out_bvalid = 1'b1;
                    n_out_end    = 1'b0;
                    n_out_last   = (r_idx == r_cursor - CUR_W'(1));
                    n_idx        = r_idx + CUR_W'(1);
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
        n_out_valid = emit ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    // The walk reads the byte before its position; everything else reads at it.
    assign rd_ptr = (n_state == ST_WALK) ? n_idx - CUR_W'(1) : n_idx;

    // Line store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_line[r_cursor[AW-1:0]] <= i_in_byte;
        end
        if (rd_ptr < LINE_LEN_C) begin
            r_rd_data <= r_line[rd_ptr[AW-1:0]];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cursor    <= '0;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_ended     <= 1'b0;
            r_seen      <= 1'b0;
            r_retype    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_ended     <= n_ended;
            r_seen      <= n_seen;
            r_retype    <= n_retype;
            r_out_valid <= n_out_valid;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        r_out_byte   <= n_out_byte;
        r_out_bvalid <= n_out_bvalid;
        r_out_end    <= n_out_end;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_byte_valid  = r_out_bvalid;
    assign o_session_end = r_out_end;
    assign o_last        = r_out_last;

    // Checks on the editor state.
    `LEE_ASSERT_NOW(a_cursor_range, 1'b1, r_cursor <= LINE_LEN_C, "cursor past line end")
    `LEE_ASSERT_NEXT(a_ended_sticky, r_ended, r_ended && $stable(r_cursor), "ended session changed")
    `LEE_ASSERT_NOW(a_end_beat, o_out_valid && o_session_end, !o_byte_valid && o_last,
        "session end beat malformed")
    `LEE_ASSERT_NOW(a_retype_idx, r_state == ST_RETYPE, r_idx < r_cursor, "retype past cursor")

endmodule
